// ----- rtl/mfcd_pkg.sv -----
// Shared types, constants and the CRC-16/Modbus byte step for the frame checker.
// No dependencies; every other file imports this package.
package mfcd_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = QAW + 1;

    localparam logic [15:0] CRC_SEED = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef enum logic [2:0] {
        POS_ADDR   = 3'd0,
        POS_FUNC   = 3'd1,
        POS_REG_HI = 3'd2,
        POS_REG_LO = 3'd3,
        POS_VAL_HI = 3'd4,
        POS_VAL_LO = 3'd5,
        POS_CRC_LO = 3'd6,
        POS_CRC_HI = 3'd7
    } t_pos;

    typedef struct packed {
        t_pos       pos;
        logic [7:0] data;
    } t_entry;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [7:0]  func_code;
        logic [15:0] reg_index;
        logic [15:0] register_value;
        logic [15:0] computed_crc;
        logic        crc_ok;
    } t_result;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/mfcd_front.sv -----
// Front end: accepts received bytes and tags each with its frame position.
// Depends on mfcd_pkg.
module mfcd_front
    import mfcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    output t_entry     o_entry
);

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [2:0] w_pos;

    assign w_pos = i_frame_start ? 3'(POS_ADDR) : r_pos;
    assign n_pos = i_accept ? w_pos + 3'd1 : r_pos;

    assign o_entry.pos  = t_pos'(w_pos);
    assign o_entry.data = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'(POS_ADDR);
        end else begin
            r_pos <= n_pos;
        end
    end

endmodule

// ----- rtl/mfcd_queue.sv -----
// Short queue of tagged bytes between the front end and the back end.
// Depends on mfcd_pkg.
module mfcd_queue
    import mfcd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_head
);

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QCW-1:0]   r_cnt;
    logic [QAW-1:0]   n_wr;
    logic [QAW-1:0]   n_rd;
    logic [QCW-1:0]   n_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QCW'(i_push) - QCW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/mfcd_back.sv -----
// Back end: runs the CRC, collects the frame fields and queues finished results.
// Depends on mfcd_pkg.
module mfcd_back
    import mfcd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_entry  i_head,
    output logic    o_pop,
    input  logic    i_res_pop,
    output logic    o_res_empty,
    output t_result o_res
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_addr;
    logic [7:0]  r_func;
    logic [15:0] r_regnum;
    logic [15:0] r_regval;
    logic [7:0]  r_crc_lo;

    t_result     r_res [2];
    logic        r_rd;
    logic        r_wr;
    logic [1:0]  r_cnt;

    logic        w_res_full;
    logic        w_res_push;
    logic        w_res_pop;
    logic [15:0] w_crc_in;
    t_result     w_res;

    assign w_res_full  = (r_cnt == 2'd2);
    assign o_res_empty = (r_cnt == 2'd0);
    assign o_res       = r_res[r_rd];
    assign w_res_pop   = i_res_pop && !o_res_empty;

    assign o_pop      = i_valid && !((i_head.pos == POS_CRC_HI) && w_res_full);
    assign w_res_push = o_pop && (i_head.pos == POS_CRC_HI);

    assign w_crc_in = (i_head.pos == POS_ADDR) ? CRC_SEED : r_crc;

    always_comb begin
        n_crc = r_crc;
        if (o_pop) begin
            unique case (i_head.pos)
                POS_ADDR, POS_FUNC, POS_REG_HI, POS_REG_LO, POS_VAL_HI, POS_VAL_LO: begin
                    n_crc = crc_feed(w_crc_in, i_head.data);
                end
                POS_CRC_LO, POS_CRC_HI: begin
                    n_crc = r_crc;
                end
            endcase
        end
    end

    always_comb begin
        w_res.slave_address  = r_addr;
        w_res.func_code      = r_func;
        w_res.reg_index      = r_regnum;
        w_res.register_value = r_regval;
        w_res.computed_crc   = r_crc;
        w_res.crc_ok         = ({i_head.data, r_crc_lo} == r_crc);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            unique case (i_head.pos)
                POS_ADDR:   r_addr         <= i_head.data;
                POS_FUNC:   r_func         <= i_head.data;
                POS_REG_HI: r_regnum[15:8] <= i_head.data;
                POS_REG_LO: r_regnum[7:0]  <= i_head.data;
                POS_VAL_HI: r_regval[15:8] <= i_head.data;
                POS_VAL_LO: r_regval[7:0]  <= i_head.data;
                POS_CRC_LO: r_crc_lo       <= i_head.data;
                POS_CRC_HI: r_res[r_wr]    <= w_res;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_SEED;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_crc <= n_crc;
            if (w_res_pop) begin
                r_rd <= ~r_rd;
            end
            if (w_res_push) begin
                r_wr <= ~r_wr;
            end
            r_cnt <= r_cnt + 2'(w_res_push) - 2'(w_res_pop);
        end
    end

endmodule

// ----- rtl/modbus_frame_check_decode.sv -----
// Top level of the Modbus RTU request frame checker and decoder.
// Depends on mfcd_pkg, mfcd_front, mfcd_queue and mfcd_back.
//
// Usage: received bytes enter through push/full, one transaction per byte,
// with i_frame_start high on the first byte of a frame. The eighth byte of a
// frame yields one result transaction on empty/pop: address, function code,
// register number, register value, the CRC-16/Modbus over the first six bytes
// and a flag that tells whether the received CRC matches it. Other bytes give
// no result. A frame start in mid-frame drops the partial frame.
// Throughput is one byte per cycle while full is low. A result reaches the
// output once its last byte has been written into the byte queue and the
// back end has read it from there and written the result register. The back
// end folds a whole byte into the CRC combinationally as it pops the byte.
// When the receiver stalls, two results are held; the byte queue of four then
// fills and full rises. Bytes that do not finish a frame keep flowing while
// results wait. Reset empties both queues and restarts the frame count.
module modbus_frame_check_decode
    import mfcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_start,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_slave_address,
    output logic [7:0]  o_func_code,
    output logic [15:0] o_reg_index,
    output logic [15:0] o_register_value,
    output logic [15:0] o_computed_crc,
    output logic        o_crc_ok
);

    logic    w_accept;
    t_entry  w_entry;
    logic    w_q_valid;
    logic    w_q_pop;
    t_entry  w_q_head;
    t_result w_res;

    assign w_accept = push && !full;

    mfcd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_entry       (w_entry)
    );

    mfcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_entry (w_entry),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_head  (w_q_head)
    );

    mfcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_head      (w_q_head),
        .o_pop       (w_q_pop),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_res       (w_res)
    );

    assign o_slave_address  = w_res.slave_address;
    assign o_func_code      = w_res.func_code;
    assign o_reg_index      = w_res.reg_index;
    assign o_register_value = w_res.register_value;
    assign o_computed_crc   = w_res.computed_crc;
    assign o_crc_ok         = w_res.crc_ok;

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("back end popped an empty byte queue");

    a_no_result_from_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty && !w_q_valid |=> empty)
        else $error("result appeared without a queued byte");

    a_last_byte_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop && (w_q_head.pos == POS_CRC_HI) |=> !empty)
        else $error("frame end did not produce a result");

endmodule
